### src/reb_pkg.sv
// shared constants and types for the rotary encoder and button event block
`timescale 1ns / 1ps

package reb_pkg;

    typedef logic [2:0] t_event;
    typedef logic [1:0] t_phase;
    typedef logic [2:0] t_cfg_index;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int CFG_DATA_WIDTH      = 16;
    localparam int TICK_WIDTH          = 16;
    localparam int PERIOD_WIDTH        = 8;
    localparam int STEP_WIDTH          = 8;

    localparam t_event EV_IDLE       = 3'd0;
    localparam t_event EV_LEFT       = 3'd1;
    localparam t_event EV_RIGHT      = 3'd2;
    localparam t_event EV_LEFT_FAST  = 3'd3;
    localparam t_event EV_RIGHT_FAST = 3'd4;
    localparam t_event EV_BUTTON     = 3'd5;
    localparam t_event EV_LONG       = 3'd6;
    localparam t_event EV_HELD       = 3'd7;

    localparam t_phase PH_RELEASED = 2'd0;
    localparam t_phase PH_DEBOUNCE = 2'd1;
    localparam t_phase PH_HOLDING  = 2'd2;

    localparam t_cfg_index CFG_STEP_INCREMENT     = 3'd0;
    localparam t_cfg_index CFG_FAST_THRESHOLD     = 3'd1;
    localparam t_cfg_index CFG_DEBOUNCE_TICKS     = 3'd2;
    localparam t_cfg_index CFG_HOLD_PERIOD_TICKS  = 3'd3;
    localparam t_cfg_index CFG_LONG_PRESS_PERIODS = 3'd4;

    localparam logic [STEP_WIDTH-1:0]   RST_STEP_INCREMENT     = 8'd5;
    localparam logic [TICK_WIDTH-1:0]   RST_FAST_THRESHOLD     = 16'd10;
    localparam logic [TICK_WIDTH-1:0]   RST_DEBOUNCE_TICKS     = 16'd5;
    localparam logic [TICK_WIDTH-1:0]   RST_HOLD_PERIOD_TICKS  = 16'd100;
    localparam logic [PERIOD_WIDTH-1:0] RST_LONG_PRESS_PERIODS = 8'd30;

endpackage

### src/rotary_encoder_button_events.sv
// rotary encoder and push button event block, top level
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_stall      | a, b, button levels, scan, fast, clear
//  output   | o_out_valid / i_out_stall    | o_event_valid, o_event_code
//  config   | i_cfg_we                     | i_cfg_index, i_cfg_data
//
// one sample per clock while o_in_stall is low; the transfer edge updates the state and
// loads the result, which is offered on the output from the next cycle
// the output register is the only stage; input stalls only while it is full and stalled
// synchronous active-low reset restores the register defaults, clears all but event data
`timescale 1ns / 1ps

module rotary_encoder_button_events
    import reb_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_a_level,
    input  logic                      i_b_level,
    input  logic                      i_button_level,
    input  logic                      i_scan_request,
    input  logic                      i_fast_mode,
    input  logic                      i_clear_request,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_event_valid,
    output logic [2:0]                o_event_code,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > TICK_WIDTH) ? COUNT_WIDTH : TICK_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [TICK_WIDTH-1:0]  TICK_MAX  = {TICK_WIDTH{1'b1}};

    logic [STEP_WIDTH-1:0]   r_step_increment;
    logic [TICK_WIDTH-1:0]   r_fast_threshold;
    logic [TICK_WIDTH-1:0]   r_debounce_ticks;
    logic [TICK_WIDTH-1:0]   r_hold_period_ticks;
    logic [PERIOD_WIDTH-1:0] r_long_press_periods;

    logic                    r_previous_a, n_previous_a;
    logic                    r_left_armed, n_left_armed;
    logic                    r_right_armed, n_right_armed;
    logic [COUNT_WIDTH-1:0]  r_left_count, n_left_count;
    logic [COUNT_WIDTH-1:0]  r_right_count, n_right_count;
    t_event                  r_pending_event, n_pending_event;
    logic [TICK_WIDTH-1:0]   r_button_tick_count, n_button_tick_count;
    logic [PERIOD_WIDTH-1:0] r_held_periods, n_held_periods;
    t_phase                  r_button_phase, n_button_phase;

    logic                    r_out_valid;
    logic                    r_event_valid;
    t_event                  r_event_code, n_event_code;

    logic                    in_xfer;
    logic                    pressed;
    logic [COUNT_WIDTH:0]    left_sum;
    logic [COUNT_WIDTH:0]    right_sum;
    logic [COUNT_WIDTH-1:0]  left_inc;
    logic [COUNT_WIDTH-1:0]  right_inc;
    logic [TICK_WIDTH-1:0]   tick_plus;
    logic [TICK_WIDTH-1:0]   tick_sat;
    logic [PERIOD_WIDTH-1:0] held_plus;

    assign o_in_stall    = r_out_valid & i_out_stall;
    assign in_xfer       = i_in_valid & ~o_in_stall;
    assign o_out_valid   = r_out_valid;
    assign o_event_valid = r_event_valid;
    assign o_event_code  = r_event_code;
    assign pressed       = ~i_button_level;

    assign left_sum  = {1'b0, r_left_count} + (COUNT_WIDTH + 1)'(r_step_increment);
    assign right_sum = {1'b0, r_right_count} + (COUNT_WIDTH + 1)'(r_step_increment);
    assign left_inc  = left_sum[COUNT_WIDTH] ? COUNT_MAX : left_sum[COUNT_WIDTH-1:0];
    assign right_inc = right_sum[COUNT_WIDTH] ? COUNT_MAX : right_sum[COUNT_WIDTH-1:0];
    assign tick_plus = r_button_tick_count + TICK_WIDTH'(1);
    assign tick_sat  = (r_button_tick_count == TICK_MAX) ? TICK_MAX : tick_plus;
    assign held_plus = r_held_periods + PERIOD_WIDTH'(1);

    always_comb begin
        n_previous_a        = r_previous_a;
        n_left_armed        = r_left_armed;
        n_right_armed       = r_right_armed;
        n_left_count        = r_left_count;
        n_right_count       = r_right_count;
        n_pending_event     = r_pending_event;
        n_button_tick_count = r_button_tick_count;
        n_held_periods      = r_held_periods;
        n_button_phase      = r_button_phase;
        n_event_code        = EV_IDLE;

        // encoder edges
        if (i_a_level != r_previous_a) begin
            n_previous_a = i_a_level;
            if (!i_a_level) begin
                if (!i_b_level) begin
                    n_left_armed = 1'b1;
                end else begin
                    n_right_armed = 1'b1;
                end
            end else begin
                if (i_b_level) begin
                    if (r_left_armed) begin
                        n_left_count    = left_inc;
                        n_pending_event = EV_LEFT;
                    end
                end else begin
                    if (r_right_armed) begin
                        n_right_count   = right_inc;
                        n_pending_event = EV_RIGHT;
                    end
                end
                n_left_armed  = 1'b0;
                n_right_armed = 1'b0;
            end
        end

        // button
        case (r_button_phase)
            PH_DEBOUNCE: begin
                if (!pressed) begin
                    n_button_phase      = PH_RELEASED;
                    n_button_tick_count = '0;
                end else if (tick_sat >= r_debounce_ticks) begin
                    n_button_phase      = PH_HOLDING;
                    n_button_tick_count = '0;
                    n_held_periods      = '0;
                end else begin
                    n_button_tick_count = tick_sat;
                end
            end
            PH_HOLDING: begin
                if (tick_plus >= r_hold_period_ticks || tick_plus == '0) begin
                    n_button_tick_count = '0;
                    if (r_held_periods < r_long_press_periods) begin
                        n_held_periods  = held_plus;
                        n_pending_event = EV_HELD;
                    end else begin
                        n_pending_event = EV_LONG;
                    end
                    if (!pressed) begin
                        n_pending_event = (n_held_periods >= r_long_press_periods)
                                          ? EV_LONG : EV_BUTTON;
                        n_button_phase  = PH_RELEASED;
                        n_held_periods  = '0;
                    end
                end else begin
                    n_button_tick_count = tick_plus;
                end
            end
            default: begin
                n_button_phase      = PH_RELEASED;
                n_button_tick_count = '0;
                if (pressed) begin
                    if (TICK_WIDTH'(1) >= r_debounce_ticks) begin
                        n_button_phase = PH_HOLDING;
                        n_held_periods = '0;
                    end else begin
                        n_button_phase      = PH_DEBOUNCE;
                        n_button_tick_count = TICK_WIDTH'(1);
                    end
                end
            end
        endcase

        if (i_clear_request) begin
            n_pending_event = EV_IDLE;
        end

        // scan
        if (i_scan_request) begin
            if (i_fast_mode) begin
                if (CMP_WIDTH'(n_left_count) >= CMP_WIDTH'(r_fast_threshold)) begin
                    n_pending_event = EV_LEFT_FAST;
                end
                if (CMP_WIDTH'(n_right_count) >= CMP_WIDTH'(r_fast_threshold)) begin
                    n_pending_event = EV_RIGHT_FAST;
                end
                n_left_count  = '0;
                n_right_count = '0;
            end
            n_event_code    = n_pending_event;
            n_pending_event = EV_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_increment     <= RST_STEP_INCREMENT;
            r_fast_threshold     <= RST_FAST_THRESHOLD;
            r_debounce_ticks     <= RST_DEBOUNCE_TICKS;
            r_hold_period_ticks  <= RST_HOLD_PERIOD_TICKS;
            r_long_press_periods <= RST_LONG_PRESS_PERIODS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STEP_INCREMENT:     r_step_increment     <= i_cfg_data[STEP_WIDTH-1:0];
                CFG_FAST_THRESHOLD:     r_fast_threshold     <= i_cfg_data[TICK_WIDTH-1:0];
                CFG_DEBOUNCE_TICKS:     r_debounce_ticks     <= i_cfg_data[TICK_WIDTH-1:0];
                CFG_HOLD_PERIOD_TICKS:  r_hold_period_ticks  <= i_cfg_data[TICK_WIDTH-1:0];
                CFG_LONG_PRESS_PERIODS: r_long_press_periods <= i_cfg_data[PERIOD_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_previous_a        <= 1'b1;
            r_left_armed        <= 1'b0;
            r_right_armed       <= 1'b0;
            r_left_count        <= '0;
            r_right_count       <= '0;
            r_pending_event     <= EV_IDLE;
            r_button_tick_count <= '0;
            r_held_periods      <= '0;
            r_button_phase      <= PH_RELEASED;
        end else if (in_xfer) begin
            r_previous_a        <= n_previous_a;
            r_left_armed        <= n_left_armed;
            r_right_armed       <= n_right_armed;
            r_left_count        <= n_left_count;
            r_right_count       <= n_right_count;
            r_pending_event     <= n_pending_event;
            r_button_tick_count <= n_button_tick_count;
            r_held_periods      <= n_held_periods;
            r_button_phase      <= n_button_phase;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_event_valid <= i_scan_request;
            r_event_code  <= n_event_code;
        end
    end

endmodule
